// ===== rtl/sclru_pkg.sv =====
// Shared types and codes of the sector cache tag engine.
// Used by sclru_cell, sclru_ctrl and sector_cache_lru_tags_unit.
`timescale 1ns / 1ps
`default_nettype none

package sclru_pkg;

    // Slot index width wide enough for the largest cache (256 entries)
    localparam int IDX_W = 8;
    localparam int TAG_W = 32;
    localparam int AGE_W = 32;
    localparam int CNT_W = 32;
    localparam int SLOT_W = 6;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_INVAL  = 2'd2;

    typedef enum logic [1:0] {
        WB_STAMP = 2'd0,
        WB_CLEAR = 2'd1,
        WB_FILL  = 2'd2
    } wb_op_t;

    // Search packet that walks the row of cells
    typedef struct packed {
        logic             vld;
        logic             inval;
        logic [TAG_W-1:0] addr;
        logic [AGE_W-1:0] age_ctr;
        logic             found;
        logic [IDX_W-1:0] hidx;
        logic [IDX_W-1:0] vidx;
        logic             vvalid;
        logic [AGE_W-1:0] vdist;
    } pkt_t;

    // Single-entry update broadcast to all cells
    typedef struct packed {
        logic             en;
        wb_op_t           op;
        logic [IDX_W-1:0] idx;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } wb_t;

endpackage

`default_nettype wire

// ===== rtl/sclru_cell.sv =====
// One cache entry (tag, age, valid) plus one stage of the search chain.
// Depends on sclru_pkg for the packet and update types.
`timescale 1ns / 1ps
`default_nettype none

module sclru_cell #(
    parameter int INDEX = 0
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire sclru_pkg::pkt_t     pkt_in,
    output sclru_pkg::pkt_t          pkt_out,
    input  wire sclru_pkg::wb_t      wb
);

    logic [sclru_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [sclru_pkg::AGE_W-1:0] age_reg, age_next;
    logic                        valid_reg, valid_next;
    sclru_pkg::pkt_t             pkt_reg, pkt_next;

    logic [sclru_pkg::AGE_W-1:0] age_dist;
    logic                        match;
    logic                        wb_hit;

    assign age_dist = pkt_in.age_ctr - age_reg;
    assign match    = (tag_reg == pkt_in.addr);
    assign wb_hit   = wb.en && (wb.idx == sclru_pkg::IDX_W'(INDEX));

    always_comb
    begin
        pkt_next = pkt_in;
        if (pkt_in.vld && !pkt_in.inval)
        begin
            // first valid match wins
            if (valid_reg && match && !pkt_in.found)
            begin
                pkt_next.found = 1'b1;
                pkt_next.hidx  = sclru_pkg::IDX_W'(INDEX);
            end
            // highest invalid entry, else oldest with ties at lower index
            if (!valid_reg)
            begin
                pkt_next.vidx   = sclru_pkg::IDX_W'(INDEX);
                pkt_next.vvalid = 1'b0;
                pkt_next.vdist  = age_dist;
            end
            else if (pkt_in.vvalid && (age_dist > pkt_in.vdist))
            begin
                pkt_next.vidx  = sclru_pkg::IDX_W'(INDEX);
                pkt_next.vdist = age_dist;
            end
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (pkt_in.vld && pkt_in.inval && match)
        begin
            valid_next = 1'b0;
        end
        if (wb_hit)
        begin
            case (wb.op)
                sclru_pkg::WB_STAMP:
                begin
                    age_next = wb.age;
                end
                sclru_pkg::WB_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                sclru_pkg::WB_FILL:
                begin
                    tag_next   = wb.tag;
                    age_next   = wb.age;
                    valid_next = 1'b1;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            age_reg   <= '0;
            valid_reg <= 1'b0;
            pkt_reg   <= '0;
        end
        else
        begin
            tag_reg   <= tag_next;
            age_reg   <= age_next;
            valid_reg <= valid_next;
            pkt_reg   <= pkt_next;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

// ===== rtl/sclru_ctrl.sv =====
// Command sequencer: launches searches, applies hit/miss/fill updates,
// keeps the age and hit/miss counters and holds the output register.
// Depends on sclru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sclru_ctrl #(
    parameter int ENTRIES = 64
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [47:0]               s_tdata,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    output logic [71:0]               m_tdata,
    output sclru_pkg::pkt_t           pkt_head,
    input  wire sclru_pkg::pkt_t      pkt_tail,
    output sclru_pkg::wb_t            wb
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [1:0]                   cmd_reg;
    logic [sclru_pkg::TAG_W-1:0]  addr_reg;
    logic [sclru_pkg::SLOT_W-1:0] fslot_reg;
    logic                         ok_reg;
    sclru_pkg::pkt_t              res_reg;
    logic [sclru_pkg::AGE_W-1:0]  age_ctr_reg, age_ctr_next;
    logic [sclru_pkg::CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [sclru_pkg::CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic                         m_tvalid_reg;
    logic                         out_hit_reg, out_hit_next;
    logic [sclru_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;

    logic [1:0]                   in_cmd;
    logic                         in_accept;
    logic                         is_scan;
    logic                         load_out;
    logic                         fill_in_range;

    assign in_cmd    = s_tdata[1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign is_scan   = in_cmd inside {sclru_pkg::CMD_LOOKUP, sclru_pkg::CMD_INVAL};
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign fill_in_range = (9'(fslot_reg) < 9'(ENTRIES));

    always_comb
    begin
        pkt_head         = '0;
        pkt_head.vld     = in_accept && is_scan;
        pkt_head.inval   = (in_cmd == sclru_pkg::CMD_INVAL);
        pkt_head.addr    = s_tdata[33:2];
        pkt_head.age_ctr = age_ctr_reg;
        pkt_head.vvalid  = 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        age_ctr_next  = age_ctr_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        out_hit_next  = 1'b0;
        out_slot_next = '0;
        wb            = '0;
        wb.op         = sclru_pkg::WB_STAMP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = is_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (pkt_tail.vld)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        sclru_pkg::CMD_LOOKUP:
                        begin
                            wb.en = 1'b1;
                            if (res_reg.found)
                            begin
                                hit_cnt_next  = hit_cnt_reg + 1'b1;
                                age_ctr_next  = age_ctr_reg + 1'b1;
                                wb.op         = sclru_pkg::WB_STAMP;
                                wb.idx        = res_reg.hidx;
                                wb.age        = age_ctr_next;
                                out_hit_next  = 1'b1;
                                out_slot_next = res_reg.hidx[sclru_pkg::SLOT_W-1:0];
                            end
                            else
                            begin
                                miss_cnt_next = miss_cnt_reg + 1'b1;
                                wb.op         = sclru_pkg::WB_CLEAR;
                                wb.idx        = res_reg.vidx;
                                out_slot_next = res_reg.vidx[sclru_pkg::SLOT_W-1:0];
                            end
                        end
                        sclru_pkg::CMD_FILL:
                        begin
                            out_slot_next = fslot_reg;
                            if (ok_reg && fill_in_range)
                            begin
                                age_ctr_next = age_ctr_reg + 1'b1;
                                wb.en        = 1'b1;
                                wb.op        = sclru_pkg::WB_FILL;
                                wb.idx       = sclru_pkg::IDX_W'(fslot_reg);
                                wb.tag       = addr_reg;
                                wb.age       = age_ctr_next;
                            end
                        end
                        default:
                        begin
                            out_slot_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            age_ctr_reg  <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            age_ctr_reg  <= age_ctr_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers: command capture, search result, output word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= in_cmd;
            addr_reg  <= s_tdata[33:2];
            fslot_reg <= s_tdata[39:34];
            ok_reg    <= s_tdata[40];
        end
        if ((state_reg == ST_SCAN) && pkt_tail.vld)
        begin
            res_reg <= pkt_tail;
        end
        if (load_out)
        begin
            out_hit_reg  <= out_hit_next;
            out_slot_reg <= out_slot_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, miss_cnt_reg, hit_cnt_reg, out_slot_reg, out_hit_reg};

endmodule

`default_nettype wire

// ===== rtl/sector_cache_lru_tags_unit.sv =====
// Tag and LRU replacement engine of a fully associative sector cache.
// Channels: s_* carries one command per transfer, m_* returns one result.
// Commands: lookup (hit slot, or victim slot that is invalidated on a miss),
// fill (validates the given slot with the new tag when the read succeeded),
// invalidate (clears every entry with a matching tag).
// The entries sit in a row of ENTRIES cells; a search packet steps one cell
// per clock, so lookup and invalidate give their result once the packet has
// passed every cell; fill and unused codes skip the search.
// One command is in work at a time: s_tready is high only while idle.
// The result sits in an output register; a new command is taken while it
// waits, and a finished command holds until m_tready frees the register.
// Reset clears all entries, the age counter and the hit/miss counters;
// no clearing pass is needed.
// Depends on sclru_pkg, sclru_cell and sclru_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_lru_tags_unit #(
    parameter int ENTRIES = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] command, [33:2] sector_address, [39:34] fill_slot, [40] read_ok
    input  wire  [47:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] hit, [6:1] slot, [38:7] hit_total, [70:39] miss_total
    output logic [71:0] m_tdata
);

    sclru_pkg::pkt_t     chain [ENTRIES+1];
    sclru_pkg::wb_t      wb;
    logic [ENTRIES-1:0]  chain_vld;

    sclru_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .pkt_head (chain[0]),
        .pkt_tail (chain[ENTRIES]),
        .wb       (wb)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        sclru_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1]),
            .wb      (wb)
        );
        assign chain_vld[i] = chain[i+1].vld;
    end

    // at most one search in flight
    a_single_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_vld) <= 1)
        else $error("more than one search packet in the chain");

    // entry updates never overlap a search
    a_wb_idle_chain: assert property (@(posedge clk) disable iff (!rst_n)
        wb.en |-> (chain_vld == '0))
        else $error("entry update while a search is in flight");

    // an entry update always comes with a result
    a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
        wb.en |=> m_tvalid)
        else $error("entry update without a result");

    // no command is taken while the search is still running
    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES].vld |-> !s_tready)
        else $error("command taken during a search");

endmodule

`default_nettype wire

// ===== test/tb_sector_cache_lru_tags_unit.sv =====
// Self-checking bench for the sector cache tag engine: lookup, fill, invalidate and unused
// command codes against an in-bench model of tags, ages, hit and miss counters.
// Depends on sclru_pkg and the sector_cache_lru_tags_unit RTL.
`timescale 1ns / 1ps

module tb_sector_cache_lru_tags_unit;

    localparam int          SLOTS      = 64;
    localparam int          ITEM_GOAL  = 1600;
    localparam int          POOL_SIZE  = 80;
    localparam int          CYCLE_CAP  = 1000000;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic        rd_ok;
        logic [5:0]  fslot;
        logic [31:0] addr;
        logic [1:0]  command;
    } cache_cmd_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  slot;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } cache_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    // Cache image and counters
    logic [31:0] tag_mem   [SLOTS];
    logic [31:0] age_mem   [SLOTS];
    logic        valid_mem [SLOTS];
    logic [31:0] age_now;
    logic [31:0] hits_now;
    logic [31:0] misses_now;
    logic        lookup_hit_seen;
    logic [5:0]  lookup_slot_seen;

    cache_cmd_t  cmd_queue [$];
    cache_resp_t expected_responses [$];
    cache_cmd_t  cmd_on_bus;
    logic [31:0] addr_pool [POOL_SIZE];

    int n_pushed = 0;
    int n_accepted = 0;
    int err_count = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int cycle_count = 0;
    bit gaps_on = 1'b0;
    bit sink_hold = 1'b0;
    bit hold_request = 1'b0;

    sector_cache_lru_tags_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        err_count++;
        $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    // Apply one accepted command to the cache image and queue its response
    task automatic predict_response(input cache_cmd_t c);
        cache_resp_t r;
        int          found;
        int          victim;
        logic [31:0] dist_i;
        logic [31:0] dist_v;
        r = '0;
        if (c.command == sclru_pkg::CMD_LOOKUP)
        begin
            found = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (found < 0 && valid_mem[i] && tag_mem[i] == c.addr)
                    found = i;
            end
            if (found >= 0)
            begin
                hits_now++;
                age_now++;
                age_mem[found] = age_now;
                r.hit = 1'b1;
                r.slot = found[5:0];
            end
            else
            begin
                // highest invalid slot wins, else oldest by wrapped distance
                victim = 0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    dist_i = age_now - age_mem[i];
                    dist_v = age_now - age_mem[victim];
                    if (!valid_mem[i])
                        victim = i;
                    else if (valid_mem[victim] && dist_i > dist_v)
                        victim = i;
                end
                misses_now++;
                valid_mem[victim] = 1'b0;
                r.slot = victim[5:0];
            end
            lookup_hit_seen = r.hit;
            lookup_slot_seen = r.slot;
        end
        else if (c.command == sclru_pkg::CMD_FILL)
        begin
            r.slot = c.fslot;
            if (c.rd_ok)
            begin
                age_now++;
                tag_mem[c.fslot] = c.addr;
                age_mem[c.fslot] = age_now;
                valid_mem[c.fslot] = 1'b1;
            end
        end
        else if (c.command == sclru_pkg::CMD_INVAL)
        begin
            // tag match clears the entry even if it is already invalid
            for (int i = 0; i < SLOTS; i++)
            begin
                if (tag_mem[i] == c.addr)
                    valid_mem[i] = 1'b0;
            end
        end
        r.hit_total = hits_now;
        r.miss_total = misses_now;
        expected_responses.push_back(r);
    endtask

    // Command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_response(cmd_on_bus);
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (cmd_queue.size() > 0)
                begin
                    cmd_on_bus = cmd_queue.pop_front();
                    s_tdata <= {7'b0, cmd_on_bus};
                    s_tvalid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 17);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and sink backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_responses.size() == 0)
                begin
                    report("result with nothing pending", 32'd0, m_tdata[31:0]);
                end
                else
                begin
                    cache_resp_t want;
                    want = expected_responses.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report("hit", 32'(want.hit), 32'(m_tdata[0]));
                    if (m_tdata[6:1] !== want.slot)
                        report("slot", 32'(want.slot), 32'(m_tdata[6:1]));
                    if (m_tdata[38:7] !== want.hit_total)
                        report("hit_total", want.hit_total, m_tdata[38:7]);
                    if (m_tdata[70:39] !== want.miss_total)
                        report("miss_total", want.miss_total, m_tdata[70:39]);
                end
            end
            if (sink_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    // Long sink stall so the output register and the engine both fill up
    initial
    begin
        wait (hold_request);
        @(negedge clk);
        sink_hold = 1'b1;
        repeat (400) @(negedge clk);
        sink_hold = 1'b0;
    end

    task automatic push_cmd(input logic [1:0] command, input logic [31:0] addr,
                            input logic [5:0] fslot, input logic rd_ok);
        cache_cmd_t c;
        c.command = command;
        c.addr = addr;
        c.fslot = fslot;
        c.rd_ok = rd_ok;
        cmd_queue.push_back(c);
        n_pushed++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed)
            @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] pick;
        int          choice;
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_mem[i] = '0;
            age_mem[i] = '0;
            valid_mem[i] = 1'b0;
        end
        age_now = '0;
        hits_now = '0;
        misses_now = '0;
        lookup_hit_seen = 1'b0;
        lookup_slot_seen = '0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty cache, failed fill, hit, duplicate tags, invalidate, unused code
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_FILL, 32'h0000_0000, 6'd63, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd63, 1'b1);
        push_cmd(sclru_pkg::CMD_FILL, 32'hFFFF_FFFF, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b1);
        push_cmd(sclru_pkg::CMD_FILL, 32'hFFFF_FFFF, 6'd0, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_INVAL, 32'hFFFF_FFFF, 6'd63, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0);
        push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1);
        push_cmd(sclru_pkg::CMD_INVAL, 32'h0000_0000, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'h0000_0000, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_FILL, 32'h0000_0000, 6'd63, 1'b1);
        push_cmd(sclru_pkg::CMD_INVAL, 32'h1234_5678, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_FILL, 32'hA5A5_A5A5, 6'd5, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'hA5A5_A5A5, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_FILL, 32'h5A5A_5A5A, 6'd5, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'hA5A5_A5A5, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_FILL, 32'h0000_0077, 6'd10, 1'b1);
        push_cmd(sclru_pkg::CMD_FILL, 32'h0000_0077, 6'd20, 1'b1);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'h0000_0077, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_INVAL, 32'h0000_0077, 6'd0, 1'b0);
        push_cmd(sclru_pkg::CMD_LOOKUP, 32'h0000_0077, 6'd0, 1'b0);
        push_cmd(CMD_UNUSED, 32'h0000_0000, 6'd0, 1'b0);
        wait_drained();

        // Backpressure: keep offering while the sink holds off
        gaps_on = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 10; i++)
            push_cmd(sclru_pkg::CMD_LOOKUP, addr_pool[$urandom_range(0, POOL_SIZE - 1)],
                     6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));

        while (n_pushed < ITEM_GOAL)
        begin
            if (n_pushed % 150 < 2)
                gaps_on = ($urandom_range(0, 3) != 0);
            if (n_pushed >= ITEM_GOAL - 250)
                gaps_on = 1'b0;
            choice = $urandom_range(0, 99);
            pick = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (choice < 70)
            begin
                // lookup, then fill the victim as the driver would after a card read
                push_cmd(sclru_pkg::CMD_LOOKUP, pick, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
                wait_drained();
                if (!lookup_hit_seen)
                    push_cmd(sclru_pkg::CMD_FILL, pick, lookup_slot_seen,
                             $urandom_range(0, 9) != 0);
            end
            else if (choice < 78)
            begin
                if ($urandom_range(0, 3) == 0)
                    pick = $urandom;
                push_cmd(sclru_pkg::CMD_INVAL, pick, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            end
            else if (choice < 86)
            begin
                push_cmd(sclru_pkg::CMD_LOOKUP, $urandom, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            end
            else if (choice < 92)
            begin
                if ($urandom_range(0, 1) == 0)
                    pick = $urandom;
                push_cmd(sclru_pkg::CMD_FILL, pick, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            end
            else if (choice < 96)
            begin
                push_cmd(CMD_UNUSED, $urandom, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            end
            else
            begin
                push_cmd(sclru_pkg::CMD_LOOKUP, pick, 6'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
            end
            // hold the queue short so the driver stays close behind
            while (cmd_queue.size() > 4)
                @(negedge clk);
        end

        gaps_on = 1'b0;
        wait_drained();
        while (expected_responses.size() > 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        if (err_count == 0 && expected_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
